// ===== src/accel_tilt_pitch_roll_macros.svh =====
`ifndef ACCEL_TILT_PITCH_ROLL_MACROS_SVH
`define ACCEL_TILT_PITCH_ROLL_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ACCTP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acctp: property failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ACCTP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acctp: property failed");

`endif

// ===== src/acctp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acctp_pkg;

	localparam int AXIS_W     = 16;
	localparam int IN_W       = 3 * AXIS_W;
	localparam int PITCH_W    = 15;
	localparam int ROLL_W     = 16;
	localparam int OUT_W      = 32;
	localparam int SQ_W       = 2 * AXIS_W - 1;
	localparam int SUM_W      = 2 * AXIS_W;
	localparam int ROOT_W     = 32;
	localparam int REM_W      = ROOT_W + 2;
	localparam int NEGX_W     = AXIS_W + 1;
	localparam int FRAC_SHIFT = 16;
	localparam int CW         = 36;
	localparam int AW         = 27;
	localparam int RND_SHIFT  = 9;
	localparam int ANG_W      = AW - RND_SHIFT;
	localparam int ATAN_LEN   = 24;
	localparam int ATAN_W     = 22;

	// atan(2^-i) in 2^-16 degree
	localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,
		22'd57,      22'd29,      22'd14,     22'd7,
		22'd4,       22'd2,       22'd1,      22'd0
	};

	localparam logic signed [AW-1:0] DEG180_FX = 27'sd11796480;
	localparam logic signed [AW-1:0] RND_BIAS  = 27'sd256;

	localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 18'sd11520;
	localparam logic signed [ANG_W-1:0] PITCH_MIN   = -18'sd11520;
	localparam logic signed [ANG_W-1:0] ROLL_LIMIT  = 18'sd23040;
	localparam logic signed [ANG_W-1:0] ROLL_MIN    = -18'sd23040;

	typedef struct packed {
		logic signed [AXIS_W-1:0] z;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] x;
	} accel_sample_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] z;
		logic signed [AXIS_W-1:0] y;
		logic signed [NEGX_W-1:0] neg_x;
	} side_t;

	typedef struct packed {
		logic [OUT_W-PITCH_W-ROLL_W-1:0] pad;
		logic signed [ROLL_W-1:0]         roll;
		logic signed [PITCH_W-1:0]        pitch;
	} tilt_result_t;

endpackage

`default_nettype wire

// ===== src/acctp_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acctp_isqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         valid_i,
	input  wire logic [acctp_pkg::SUM_W-1:0]  rad_i,
	input  wire acctp_pkg::side_t             side_i,
	output logic                              valid_o,
	output logic [acctp_pkg::ROOT_W-1:0]      root_o,
	output acctp_pkg::side_t                  side_o
);

	localparam int STEPS  = acctp_pkg::ROOT_W;
	localparam int ROOT_W = acctp_pkg::ROOT_W;
	localparam int REM_W  = acctp_pkg::REM_W;
	localparam int SUM_W  = acctp_pkg::SUM_W;

	logic                   valid_s [STEPS];
	logic [ROOT_W-1:0]      root_s  [STEPS];
	logic [REM_W-1:0]       rem_s   [STEPS];
	logic [SUM_W-1:0]       rad_s   [STEPS];
	acctp_pkg::side_t       side_s  [STEPS];

	// one root bit per stage; radicand is rad_i * 2^32, low half all zero
	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic                v_in;
		logic [ROOT_W-1:0]   q_in;
		logic [REM_W-1:0]    r_in;
		logic [SUM_W-1:0]    d_in;
		acctp_pkg::side_t    x_in;
		logic [REM_W+1:0]    r_sh;
		logic [REM_W+1:0]    trial;

		if (j == 0) begin : g_first
			assign v_in = valid_i;
			assign q_in = '0;
			assign r_in = '0;
			assign d_in = rad_i;
			assign x_in = side_i;
		end else begin : g_next
			assign v_in = valid_s[j-1];
			assign q_in = root_s[j-1];
			assign r_in = rem_s[j-1];
			assign d_in = rad_s[j-1];
			assign x_in = side_s[j-1];
		end

		assign r_sh  = {r_in, d_in[SUM_W-1 -: 2]};
		assign trial = {{(REM_W-ROOT_W){1'b0}}, q_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (adv) begin
				valid_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (r_sh >= trial) begin
					rem_s[j]  <= REM_W'(r_sh - trial);
					root_s[j] <= {q_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[j]  <= REM_W'(r_sh);
					root_s[j] <= {q_in[ROOT_W-2:0], 1'b0};
				end
				rad_s[j]  <= {d_in[SUM_W-3:0], 2'b00};
				side_s[j] <= x_in;
			end
		end
	end

	assign valid_o = valid_s[STEPS-1];
	assign root_o  = root_s[STEPS-1];
	assign side_o  = side_s[STEPS-1];

endmodule

`default_nettype wire

// ===== src/acctp_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acctp_cordic #(
	parameter int ITERS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               adv,
	input  wire logic                               valid_i,
	input  wire logic signed [acctp_pkg::CW-1:0]    x_i,
	input  wire logic signed [acctp_pkg::CW-1:0]    y_i,
	output logic                                    valid_o,
	output logic signed [acctp_pkg::ANG_W-1:0]      angle_o
);

	localparam int CW     = acctp_pkg::CW;
	localparam int AW     = acctp_pkg::AW;
	localparam int ANG_W  = acctp_pkg::ANG_W;
	localparam int ATAN_W = acctp_pkg::ATAN_W;

	logic                   valid_s [ITERS+1];
	logic                   zero_s  [ITERS+1];
	logic signed [CW-1:0]   x_s     [ITERS+1];
	logic signed [CW-1:0]   y_s     [ITERS+1];
	logic signed [AW-1:0]   acc_s   [ITERS+1];

	logic                   valid_sn;
	logic signed [ANG_W-1:0] angle_sn;

	logic                   in_zero;
	logic                   in_neg;
	logic signed [AW-1:0]   acc_init;
	logic signed [AW-1:0]   acc_rnd;

	// fold the left half plane onto the right, start at +-180 degrees
	assign in_zero  = (x_i == '0) && (y_i == '0);
	assign in_neg   = x_i[CW-1];
	assign acc_init = !in_neg ? '0 :
		(y_i[CW-1] ? -acctp_pkg::DEG180_FX : acctp_pkg::DEG180_FX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= in_zero;
			x_s[0]    <= in_neg ? -x_i : x_i;
			y_s[0]    <= in_neg ? -y_i : y_i;
			acc_s[0]  <= acc_init;
		end
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic signed [AW-1:0] step;

		assign xs   = x_s[i] >>> i;
		assign ys   = y_s[i] >>> i;
		assign step = $signed({{(AW-ATAN_W){1'b0}}, acctp_pkg::ATAN_TABLE[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (adv) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i][CW-1]) begin
					x_s[i+1]   <= x_s[i] - ys;
					y_s[i+1]   <= y_s[i] + xs;
					acc_s[i+1] <= acc_s[i] - step;
				end else begin
					x_s[i+1]   <= x_s[i] + ys;
					y_s[i+1]   <= y_s[i] - xs;
					acc_s[i+1] <= acc_s[i] + step;
				end
			end
		end
	end

	// round to 1/128 degree, floor after bias
	assign acc_rnd = acc_s[ITERS] + acctp_pkg::RND_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (adv) begin
			valid_sn <= valid_s[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_sn <= zero_s[ITERS] ? '0 : acc_rnd[AW-1:acctp_pkg::RND_SHIFT];
		end
	end

	assign valid_o = valid_sn;
	assign angle_o = angle_sn;

endmodule

`default_nettype wire

// ===== src/acctp_ofifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acctp_ofifo (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire acctp_pkg::tilt_result_t  push_data,
	output logic                          room,
	output logic                          m_valid,
	input  wire logic                     m_ready,
	output acctp_pkg::tilt_result_t       m_data
);

	localparam int DEPTH = 2;

	acctp_pkg::tilt_result_t mem_q [DEPTH];
	logic                    wr_ptr_q;
	logic                    rd_ptr_q;
	logic [1:0]              cnt_q;
	logic                    pop;

	assign room    = (cnt_q != 2'(DEPTH));
	assign m_valid = (cnt_q != 2'd0);
	assign m_data  = mem_q[rd_ptr_q];
	assign pop     = m_valid & m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/accel_tilt_pitch_roll.sv =====
// Tilt from one three-axis accelerometer sample: pitch = atan2(-x, sqrt(y^2 + z^2)) and
// roll = atan2(y, z), both in signed 1/128 degree (pitch -90..+90, roll -180..+180),
// atan2(0,0) giving 0. While the output buffer has room, the block takes one sample per
// clock and gives one result per sample, in order. On its way to the master side a result
// passes registers that take in, square and sum the sample, a square root of one bit per
// stage, then two CORDIC pipelines of ANGLE_ITERATIONS stages plus a setup and a rounding
// stage, and a two-entry output buffer. A stall on the master side holds the whole pipeline
// once that buffer is full.
`timescale 1ns / 1ps
`default_nettype none

module accel_tilt_pitch_roll #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // pitch_angle, roll_angle, zero pad
);

	localparam int AXIS_W  = acctp_pkg::AXIS_W;
	localparam int CW      = acctp_pkg::CW;
	localparam int ANG_W   = acctp_pkg::ANG_W;
	localparam int SQ_W    = acctp_pkg::SQ_W;
	localparam int SUM_W   = acctp_pkg::SUM_W;
	localparam int ROOT_W  = acctp_pkg::ROOT_W;
	localparam int NEGX_W  = acctp_pkg::NEGX_W;
	localparam int FRAC    = acctp_pkg::FRAC_SHIFT;
	localparam int PITCH_W = acctp_pkg::PITCH_W;
	localparam int ROLL_W  = acctp_pkg::ROLL_W;

	logic                          adv;

	acctp_pkg::accel_sample_t      smp_in;
	acctp_pkg::accel_sample_t      smp_s1;
	logic                          valid_s1;

	logic signed [2*AXIS_W-1:0]    sqy;
	logic signed [2*AXIS_W-1:0]    sqz;
	logic signed [NEGX_W-1:0]      negx;
	logic [SQ_W-1:0]               sqy_s2;
	logic [SQ_W-1:0]               sqz_s2;
	acctp_pkg::side_t              side_s2;
	logic                          valid_s2;

	logic [SUM_W-1:0]              sum_s3;
	acctp_pkg::side_t              side_s3;
	logic                          valid_s3;

	logic                          rt_valid;
	logic [ROOT_W-1:0]             rt_root;
	acctp_pkg::side_t              rt_side;

	logic signed [CW-1:0]          p_x;
	logic signed [CW-1:0]          p_y;
	logic signed [CW-1:0]          r_x;
	logic signed [CW-1:0]          r_y;
	logic                          p_valid;
	logic                          r_valid;
	logic signed [ANG_W-1:0]       p_angle;
	logic signed [ANG_W-1:0]       r_angle;

	acctp_pkg::tilt_result_t       res;
	acctp_pkg::tilt_result_t       out_data;
	logic                          push;
	logic                          room;

	assign adv           = room;
	assign s_axis_tready = adv;
	assign smp_in        = s_axis_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign sqy  = $signed(smp_s1.y) * $signed(smp_s1.y);
	assign sqz  = $signed(smp_s1.z) * $signed(smp_s1.z);
	assign negx = -$signed({smp_s1.x[AXIS_W-1], smp_s1.x});

	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s1        <= smp_in;
			sqy_s2        <= sqy[SQ_W-1:0];
			sqz_s2        <= sqz[SQ_W-1:0];
			side_s2.z     <= smp_s1.z;
			side_s2.y     <= smp_s1.y;
			side_s2.neg_x <= negx;
			sum_s3        <= {1'b0, sqy_s2} + {1'b0, sqz_s2};
			side_s3       <= side_s2;
		end
	end

	acctp_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (valid_s3),
		.rad_i   (sum_s3),
		.side_i  (side_s3),
		.valid_o (rt_valid),
		.root_o  (rt_root),
		.side_o  (rt_side)
	);

	assign p_x = $signed({{(CW-ROOT_W){1'b0}}, rt_root});
	assign p_y = $signed({{(CW-NEGX_W-FRAC){rt_side.neg_x[NEGX_W-1]}},
		rt_side.neg_x, {FRAC{1'b0}}});
	assign r_x = $signed({{(CW-AXIS_W-FRAC){rt_side.z[AXIS_W-1]}}, rt_side.z, {FRAC{1'b0}}});
	assign r_y = $signed({{(CW-AXIS_W-FRAC){rt_side.y[AXIS_W-1]}}, rt_side.y, {FRAC{1'b0}}});

	acctp_cordic #(
		.ITERS (ANGLE_ITERATIONS)
	) u_cordic_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (rt_valid),
		.x_i     (p_x),
		.y_i     (p_y),
		.valid_o (p_valid),
		.angle_o (p_angle)
	);

	acctp_cordic #(
		.ITERS (ANGLE_ITERATIONS)
	) u_cordic_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (rt_valid),
		.x_i     (r_x),
		.y_i     (r_y),
		.valid_o (r_valid),
		.angle_o (r_angle)
	);

	// clamp to the output ranges
	always_comb begin
		res = '0;
		if (p_angle > acctp_pkg::PITCH_LIMIT) begin
			res.pitch = acctp_pkg::PITCH_LIMIT[PITCH_W-1:0];
		end else if (p_angle < acctp_pkg::PITCH_MIN) begin
			res.pitch = acctp_pkg::PITCH_MIN[PITCH_W-1:0];
		end else begin
			res.pitch = p_angle[PITCH_W-1:0];
		end
		if (r_angle > acctp_pkg::ROLL_LIMIT) begin
			res.roll = acctp_pkg::ROLL_LIMIT[ROLL_W-1:0];
		end else if (r_angle < acctp_pkg::ROLL_MIN) begin
			res.roll = acctp_pkg::ROLL_MIN[ROLL_W-1:0];
		end else begin
			res.roll = r_angle[ROLL_W-1:0];
		end
	end

	assign push = adv & p_valid & r_valid;

	acctp_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.room      (room),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (out_data)
	);

	assign m_axis_tdata = out_data;

endmodule

`default_nettype wire

// ===== src/acctp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "accel_tilt_pitch_roll_macros.svh"

module acctp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [47:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	logic signed [acctp_pkg::PITCH_W-1:0] pitch_f;
	logic signed [acctp_pkg::ROLL_W-1:0]  roll_f;
	logic                                 pitch_ok;
	logic                                 roll_ok;
	logic                                 in_wait;
	logic                                 out_wait;

	assign pitch_f  = m_axis_tdata[14:0];
	assign roll_f   = m_axis_tdata[30:15];
	assign pitch_ok = (pitch_f <= acctp_pkg::PITCH_LIMIT) && (pitch_f >= acctp_pkg::PITCH_MIN);
	assign roll_ok  = (roll_f <= acctp_pkg::ROLL_LIMIT) && (roll_f >= acctp_pkg::ROLL_MIN);
	assign in_wait  = s_axis_tvalid & ~s_axis_tready;
	assign out_wait = m_axis_tvalid & ~m_axis_tready;

	`ACCTP_ASSERT_IMP(a_stall_has_output, !s_axis_tready, m_axis_tvalid)
	`ACCTP_ASSERT_IMP(a_pitch_range, m_axis_tvalid, pitch_ok)
	`ACCTP_ASSERT_IMP(a_roll_range, m_axis_tvalid, roll_ok)
	`ACCTP_ASSERT_NXT(a_in_hold, in_wait, s_axis_tvalid && $stable(s_axis_tdata))
	`ACCTP_ASSERT_NXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind accel_tilt_pitch_roll acctp_checker u_acctp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tilt_monitor.sv =====
`timescale 1ns / 1ps

module tilt_monitor #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // pitch_angle, roll_angle, zero pad
	output int          mismatch_count,
	output int          pending
);

	localparam int     STEP_COUNT = 24;
	localparam longint HALF_TURN  = 64'sd11796480;
	localparam longint PITCH_SPAN = 64'sd11520;
	localparam longint ROLL_SPAN  = 64'sd23040;

	// atan(2^-i) in 2^-16 degree
	localparam longint ATAN_DEG [STEP_COUNT] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	acctp_pkg::tilt_result_t tilt_queue [$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// atan2(vy, vx) in 1/128 degree, clamped to +-span
	function automatic longint vector_angle(longint vy, longint vx, longint span);
		longint acc;
		longint xs;
		longint ys;
		longint r;
		acc = 0;
		if (vx == 0 && vy == 0)
			return 0;
		if (vx < 0) begin
			acc = (vy >= 0) ? HALF_TURN : -HALF_TURN;
			vx = -vx;
			vy = -vy;
		end
		for (int i = 0; i < ANGLE_ITERATIONS && i < STEP_COUNT; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (vy < 0) begin
				vx = vx - ys;
				vy = vy + xs;
				acc = acc - ATAN_DEG[i];
			end else begin
				vx = vx + ys;
				vy = vy - xs;
				acc = acc + ATAN_DEG[i];
			end
		end
		r = (acc + 256) >>> 9;
		if (r > span)
			r = span;
		if (r < -span)
			r = -span;
		return r;
	endfunction

	function automatic acctp_pkg::tilt_result_t tilt_of_accel(acctp_pkg::accel_sample_t a);
		acctp_pkg::tilt_result_t t;
		longint ax;
		longint ay;
		longint az;
		longint unsigned sumsq;
		longint mag;
		longint p;
		longint r;
		ax = a.x;
		ay = a.y;
		az = a.z;
		sumsq = ay * ay + az * az;
		mag = int_sqrt(sumsq << 32);
		p = vector_angle(-ax * 65536, mag, PITCH_SPAN);
		r = vector_angle(ay * 65536, az * 65536, ROLL_SPAN);
		t.pad = '0;
		t.pitch = p[acctp_pkg::PITCH_W-1:0];
		t.roll = r[acctp_pkg::ROLL_W-1:0];
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		acctp_pkg::tilt_result_t got;
		acctp_pkg::tilt_result_t due;
		if (!arst_n) begin
			tilt_queue.delete();
			mismatch_count = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (tilt_queue.size() == 0) begin
					$display("%0t unexpected result: expected none, actual pitch %0d roll %0d",
						$time, got.pitch, got.roll);
					mismatch_count++;
				end else begin
					due = tilt_queue.pop_front();
					if (got.pitch !== due.pitch) begin
						$display("%0t pitch mismatch: expected %0d actual %0d",
							$time, due.pitch, got.pitch);
						mismatch_count++;
					end
					if (got.roll !== due.roll) begin
						$display("%0t roll mismatch: expected %0d actual %0d",
							$time, due.roll, got.roll);
						mismatch_count++;
					end
					if (got.pad !== due.pad) begin
						$display("%0t pad mismatch: expected %0b actual %0b",
							$time, due.pad, got.pad);
						mismatch_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				tilt_queue.push_back(tilt_of_accel(s_axis_tdata));
			pending = tilt_queue.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int ITERATIONS  = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 150;

	localparam shortint AXIS_EXTREMES [6] = '{-32768, -32767, -1, 0, 1, 32767};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // accel_x, accel_y, accel_z
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // pitch_angle, roll_angle, zero pad

	int mismatch_count;
	int pending;
	int src_idle_pct;
	int sink_idle_pct;
	int idle_cycles;

	accel_tilt_pitch_roll #(
		.ANGLE_ITERATIONS(ITERATIONS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	tilt_monitor #(
		.ANGLE_ITERATIONS(ITERATIONS)
	) i_tilt_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic shortint axis_count();
		case ($urandom_range(9))
			0, 1, 2, 3: return shortint'($urandom);
			4: return AXIS_EXTREMES[$urandom_range(5)];
			5: return shortint'(int'($urandom_range(16)) - 8);
			6: return 16'sd0;
			7: return shortint'(($urandom_range(1) ? 32767 : -32768) +
				($urandom_range(1) ? -1 : 1) * int'($urandom_range(255)));
			default: return shortint'(int'($urandom_range(2047)) - 1024);
		endcase
	endfunction

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic send_accel(input shortint ax, input shortint ay, input shortint az);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {16'($urandom), 32'($urandom)};
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {az, ay, ax};
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++)
			send_accel(axis_count(), axis_count(), axis_count());
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		idle_cycles = 0;
		src_idle_pct = 34;
		sink_idle_pct = 76;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_accel(0, 0, 0);
		send_accel(32767, 0, 0);
		send_accel(-32768, 0, 0);
		send_accel(1, 0, 0);
		send_accel(-1, 0, 0);
		send_accel(0, 0, -1);
		send_accel(0, 0, -32768);
		send_accel(0, 1, -32768);
		send_accel(0, -1, -32768);
		send_accel(0, 32767, 0);
		send_accel(0, -32768, 0);
		send_accel(0, 0, 32767);
		send_accel(0, -32768, -32768);
		send_accel(0, 32767, -32768);
		send_accel(-32768, -32768, -32768);
		send_accel(32767, 32767, 32767);
		send_accel(-32768, 32767, -32768);
		send_accel(32767, -32768, 32767);
		send_accel(-32768, 0, -32768);
		send_accel(12345, -1, 0);
		send_accel(-7, 3, -5);
		drain();

		send_random(PHASE_ITEMS);
		src_idle_pct = 76;
		sink_idle_pct = 34;
		send_random(PHASE_ITEMS);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		send_random(PHASE_ITEMS);
		drain();

		repeat (ITERATIONS + 45) @(negedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== accel_tilt_pitch_roll.f =====
+incdir+src
src/acctp_pkg.sv
src/acctp_isqrt.sv
src/acctp_cordic.sv
src/acctp_ofifo.sv
src/accel_tilt_pitch_roll.sv
src/acctp_checker.sv
tb/tilt_monitor.sv
tb/tb.sv
